// ----- design/btin_pkg.sv -----
package btin_pkg;

   localparam int CHILD_W = 31;

   typedef enum logic [2:0] {
      FUNC_LOOKUP   = 3'd0,
      FUNC_NEW_ROOT = 3'd1,
      FUNC_INSERT   = 3'd2,
      FUNC_REMOVE   = 3'd3,
      FUNC_FIND     = 3'd4,
      FUNC_WRITE    = 3'd5,
      FUNC_READ     = 3'd6,
      FUNC_NONE     = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_CHILD  = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_TOO_FEW   = 3'd4
   } status_type;

   localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] key_in;
      logic [30:0] child_in;
      logic [30:0] old_child;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic [30:0] child_out;
      logic [31:0] key_out;
      logic [7:0]  index_out;
      logic [8:0]  count_out;
      logic [2:0]  status;
   } rsp_type;

endpackage

// ----- design/btree_internal_node_engine.sv -----
// b+ tree internal node engine: keeps one internal node of (key, child) pairs
// in a single-port-write, single-port-read memory and runs one operation per item.
// req channel: req_valid/req_stall with req_data (func, key, children, position).
// rsp channel: rsp_valid/rsp_stall with rsp_data; exactly one result per item.
// the csr port (apb style, pready always high) holds max_entries at address 0.
// one item at a time: req_stall is high from acceptance until the result has
// been taken. entries are read through the one memory read port, one entry per
// step of the sequencer, each step an address state then a registered-data state.
// lookup is a binary search over the keys; find child and insert scan for the
// child, insert then shifts the entries above it up; remove shifts the entries
// above it down; new root and write key only write, read entry reads one entry.
// a stalled result is held in the output register until taken.
// reset empties the node (count zero) and sets max_entries to 255; the entry
// memory is not cleared, an entry never written reads as anything.
module btree_internal_node_engine #(
   parameter int NODE_CAPACITY = 256,
   parameter int KEY_WIDTH     = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  btin_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output btin_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [0:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int AW = $clog2(NODE_CAPACITY);
   localparam int CW = AW + 1;
   localparam int CH = btin_pkg::CHILD_W;

   typedef enum logic [3:0] {
      IDLE, FIND_A, FIND_D, SHUP_A, SHUP_D, SHDN_A, SHDN_D,
      LOOK_A, LOOK_D, RD_D, RESP
   } state_type;

   state_type         state_ff, state_in;
   btin_pkg::req_type req_ff, req_in;
   btin_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [7:0]        max_ff, max_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic              wr_en, wr_child_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [KEY_WIDTH-1:0] wr_key, rd_key;
   logic [CH-1:0]     wr_child, rd_child;
   logic [CW-1:0]     limit, mid, pos_w;
   logic              pos_bad;
   logic [KEY_WIDTH-1:0] key_m;
   logic              csr_wr;

   btin_store #(.DEPTH(NODE_CAPACITY), .KW(KEY_WIDTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_child_en(wr_child_en), .wr_addr(wr_addr),
      .wr_key(wr_key), .wr_child(wr_child), .rd_addr(rd_addr), .rd_key_ff(rd_key),
      .rd_child_ff(rd_child)
   );

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign prdata    = (paddr == btin_pkg::REG_MAX_ENTRIES) ? {24'd0, max_ff} : 32'd0;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == RESP);
   assign rsp_data  = rsp_ff;

   assign limit = (32'(max_ff) + 32'd1 > 32'(NODE_CAPACITY)) ? CW'(NODE_CAPACITY)
                                                             : CW'(32'(max_ff) + 32'd1);
   assign mid   = CW'((lo_ff + hi_ff) >> 1);
   assign pos_w = CW'(req_ff.position);
   assign pos_bad = (32'(req_ff.position) >= 32'(count_ff));
   assign key_m = KEY_WIDTH'(req_ff.key_in);

   function automatic btin_pkg::rsp_type mk(input logic [CH-1:0] c, input logic [31:0] k,
                                            input logic [7:0] i, input logic [CW-1:0] n,
                                            input btin_pkg::status_type s);
      btin_pkg::rsp_type r;
      r.child_out = c; r.key_out = k; r.index_out = i;
      r.count_out = 9'(n); r.status = s;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff;
      count_in = count_ff; idx_in = idx_ff; lo_in = lo_ff; hi_in = hi_ff;
      max_in   = csr_wr && paddr == btin_pkg::REG_MAX_ENTRIES ? pwdata[7:0] : max_ff;
      wr_en = 1'b0; wr_child_en = 1'b1; wr_addr = '0; wr_key = key_m;
      wr_child = req_ff.child_in;
      rd_addr = AW'(idx_ff);
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               state_in = FIND_A;
               case (btin_pkg::func_type'(req_data.func))
                  btin_pkg::FUNC_LOOKUP: begin
                     lo_in = CW'(1); hi_in = count_ff - CW'(1);
                     state_in = LOOK_A;
                     if (count_ff < CW'(2)) begin
                        rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_TOO_FEW);
                        state_in = RESP;
                     end
                  end
                  btin_pkg::FUNC_INSERT, btin_pkg::FUNC_FIND: state_in = FIND_A;
                  btin_pkg::FUNC_NEW_ROOT, btin_pkg::FUNC_REMOVE, btin_pkg::FUNC_WRITE,
                  btin_pkg::FUNC_READ: state_in = FIND_A;
                  default: begin
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_OK);
                     state_in = RESP;
                  end
               endcase
               // single-step ops are dispatched from FIND_A by func
               if (btin_pkg::func_type'(req_data.func) == btin_pkg::FUNC_NEW_ROOT) begin
                  wr_en = 1'b1; wr_addr = '0; wr_child = req_data.old_child;
                  idx_in = CW'(1);
               end
            end
         end
         FIND_A: begin
            case (btin_pkg::func_type'(req_ff.func))
               btin_pkg::FUNC_NEW_ROOT: begin
                  wr_en = 1'b1; wr_addr = AW'(1);
                  count_in = CW'(2);
                  rsp_in = mk('0, '0, '0, CW'(2), btin_pkg::ST_OK);
                  state_in = RESP;
               end
               btin_pkg::FUNC_WRITE: begin
                  if (pos_bad) begin
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_BAD_INDEX);
                  end else begin
                     wr_en = 1'b1; wr_child_en = 1'b0; wr_addr = AW'(pos_w);
                     rd_addr = AW'(pos_w);
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_OK);
                  end
                  state_in = RESP;
               end
               btin_pkg::FUNC_READ: begin
                  rd_addr = AW'(pos_w);
                  if (pos_bad) begin
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_BAD_INDEX);
                     state_in = RESP;
                  end else begin
                     state_in = RD_D;
                  end
               end
               btin_pkg::FUNC_REMOVE: begin
                  if (pos_bad) begin
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_BAD_INDEX);
                     state_in = RESP;
                  end else begin
                     idx_in = pos_w + CW'(1);
                     state_in = SHDN_A;
                  end
               end
               default: begin
                  // linear scan for old_child
                  if (idx_ff >= count_ff) begin
                     rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_NO_CHILD);
                     state_in = RESP;
                  end else begin
                     state_in = FIND_D;
                  end
               end
            endcase
         end
         FIND_D: begin
            if (rd_child == req_ff.old_child) begin
               if (btin_pkg::func_type'(req_ff.func) == btin_pkg::FUNC_FIND) begin
                  rsp_in = mk('0, '0, 8'(idx_ff), count_ff, btin_pkg::ST_OK);
                  state_in = RESP;
               end else if (count_ff >= limit) begin
                  rsp_in = mk('0, '0, '0, count_ff, btin_pkg::ST_FULL);
                  state_in = RESP;
               end else begin
                  lo_in = idx_ff + CW'(1);   // slot for the new pair
                  idx_in = count_ff;
                  state_in = SHUP_A;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = FIND_A;
            end
         end
         SHUP_A: begin
            if (idx_ff == lo_ff) begin
               wr_en = 1'b1; wr_addr = AW'(lo_ff);
               count_in = count_ff + CW'(1);
               rsp_in = mk('0, '0, 8'(lo_ff), count_ff + CW'(1), btin_pkg::ST_OK);
               state_in = RESP;
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = SHUP_D;
            end
         end
         SHUP_D: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff);
            wr_key = rd_key; wr_child = rd_child;
            idx_in = idx_ff - CW'(1);
            state_in = SHUP_A;
         end
         SHDN_A: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               rsp_in = mk('0, '0, '0, count_ff - CW'(1), btin_pkg::ST_OK);
               state_in = RESP;
            end else begin
               state_in = SHDN_D;
            end
         end
         SHDN_D: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(1));
            wr_key = rd_key; wr_child = rd_child;
            idx_in = idx_ff + CW'(1);
            state_in = SHDN_A;
         end
         LOOK_A: begin
            if (lo_ff > hi_ff) begin
               rd_addr = AW'(lo_ff - CW'(1));
               idx_in = '0;
               state_in = RD_D;
            end else begin
               rd_addr = AW'(mid);
               idx_in = mid;
               state_in = LOOK_D;
            end
         end
         LOOK_D: begin
            if (rd_key <= key_m) lo_in = idx_ff + CW'(1);
            else hi_in = idx_ff - CW'(1);
            state_in = LOOK_A;
         end
         RD_D: begin
            if (btin_pkg::func_type'(req_ff.func) == btin_pkg::FUNC_READ)
               rsp_in = mk(rd_child, 32'(rd_key), '0, count_ff, btin_pkg::ST_OK);
            else
               rsp_in = mk(rd_child, '0, '0, count_ff, btin_pkg::ST_OK);
            state_in = RESP;
         end
         RESP: begin
            if (!rsp_stall) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         max_ff   <= 8'd255;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff   <= max_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NODE_CAPACITY)) else $error("entry count above capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("ready while result pending");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && !req_valid) |=> $stable(count_ff))
      else $error("count changed while idle");
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.count_out == 9'(count_ff))
      else $error("result count mismatch");

endmodule

// ----- design/btin_store.sv -----
module btin_store #(
   parameter int DEPTH = 256,
   parameter int KW    = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          wr_child_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [KW-1:0]                 wr_key,
   input  logic [btin_pkg::CHILD_W-1:0]  wr_child,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [KW-1:0]                 rd_key_ff,
   output logic [btin_pkg::CHILD_W-1:0]  rd_child_ff
);

   logic [KW-1:0]                key_mem   [DEPTH];
   logic [btin_pkg::CHILD_W-1:0] child_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         // a key-only write leaves the child in place
         if (wr_child_en) begin
            child_mem[wr_addr] <= wr_child;
         end
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_child_ff <= child_mem[rd_addr];
   end

endmodule

// ----- dv/tb_btree_internal_node_engine.sv -----
`timescale 1ns / 100ps

module tb_btree_internal_node_engine;

   localparam int CAP       = 256;
   localparam int HANG_MAX  = 20000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   btin_pkg::req_type    req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   btin_pkg::rsp_type    rsp_data;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [0:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   btree_internal_node_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // shadow copy of the node
   logic [31:0] node_keys [CAP];
   logic [30:0] node_kids [CAP];
   int          node_count;
   int          fanout;
   bit          key0_known;

   btin_pkg::rsp_type expected_q[$];
   int          mismatches;
   int          idle_cycles;
   bit          send_gaps;
   bit          stall_on;
   int          stall_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic btin_pkg::rsp_type node_apply(btin_pkg::req_type r);
      btin_pkg::rsp_type o;
      int      lo;
      int      hi;
      int      mid;
      int      hit;
      int      lim;
      o = '0;
      hit = -1;
      for (int i = 0; i < node_count; i++) begin
         if (hit < 0 && node_kids[i] == r.old_child) hit = i;
      end
      lim = (fanout + 1 > CAP) ? CAP : fanout + 1;
      case (btin_pkg::func_type'(r.func))
         btin_pkg::FUNC_LOOKUP: begin
            if (node_count < 2) begin
               o.status = btin_pkg::ST_TOO_FEW;
            end else begin
               lo = 1;
               hi = node_count - 1;
               while (lo <= hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (node_keys[mid] <= r.key_in) lo = mid + 1;
                  else hi = mid - 1;
               end
               o.child_out = node_kids[lo - 1];
            end
         end
         btin_pkg::FUNC_NEW_ROOT: begin
            node_kids[0] = r.old_child;
            node_keys[1] = r.key_in;
            node_kids[1] = r.child_in;
            node_count = 2;
            key0_known = 1'b0;
         end
         btin_pkg::FUNC_INSERT: begin
            if (hit < 0) begin
               o.status = btin_pkg::ST_NO_CHILD;
            end else if (node_count >= lim) begin
               o.status = btin_pkg::ST_FULL;
            end else begin
               for (int i = node_count; i > hit + 1; i--) begin
                  node_keys[i] = node_keys[i - 1];
                  node_kids[i] = node_kids[i - 1];
               end
               node_keys[hit + 1] = r.key_in;
               node_kids[hit + 1] = r.child_in;
               node_count++;
               o.index_out = 8'(hit + 1);
            end
         end
         btin_pkg::FUNC_REMOVE: begin
            if (r.position >= node_count) begin
               o.status = btin_pkg::ST_BAD_INDEX;
            end else begin
               for (int i = r.position + 1; i < node_count; i++) begin
                  node_keys[i - 1] = node_keys[i];
                  node_kids[i - 1] = node_kids[i];
               end
               node_count--;
               if (r.position == 0) key0_known = 1'b1;
            end
         end
         btin_pkg::FUNC_FIND: begin
            if (hit < 0) o.status = btin_pkg::ST_NO_CHILD;
            else o.index_out = 8'(hit);
         end
         btin_pkg::FUNC_WRITE: begin
            if (r.position >= node_count) begin
               o.status = btin_pkg::ST_BAD_INDEX;
            end else begin
               node_keys[r.position] = r.key_in;
               if (r.position == 0) key0_known = 1'b1;
            end
         end
         btin_pkg::FUNC_READ: begin
            if (r.position >= node_count) begin
               o.status = btin_pkg::ST_BAD_INDEX;
            end else begin
               o.child_out = node_kids[r.position];
               o.key_out   = node_keys[r.position];
            end
         end
         default: ;
      endcase
      o.count_out = 9'(node_count);
      return o;
   endfunction

   task automatic send_item(btin_pkg::req_type r);
      // key 0 may never have been written: turn such a read into a write
      if (btin_pkg::func_type'(r.func) == btin_pkg::FUNC_READ && r.position == 0 &&
          node_count > 0 && !key0_known)
         r.func = btin_pkg::FUNC_WRITE;
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(node_apply(r));
   endtask

   task automatic send_op(btin_pkg::func_type f, logic [31:0] k, logic [30:0] c,
                          logic [30:0] oc, logic [7:0] p);
      btin_pkg::req_type r;
      r.func      = f;
      r.key_in    = k;
      r.child_in  = c;
      r.old_child = oc;
      r.position  = p;
      send_item(r);
   endtask

   function automatic btin_pkg::req_type random_item();
      btin_pkg::req_type r;
      int      pick;
      r.func      = btin_pkg::func_type'($urandom_range(0, 7));
      r.key_in    = $urandom;
      r.child_in  = 31'($urandom);
      r.old_child = 31'($urandom);
      r.position  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) r.func = btin_pkg::FUNC_INSERT;
      else if (pick < 43 || node_count < 2) r.func = btin_pkg::FUNC_NEW_ROOT;
      if (node_count > 0 && $urandom_range(0, 9) != 0)
         r.old_child = node_kids[$urandom_range(0, node_count - 1)];
      if (node_count > 0 && $urandom_range(0, 7) != 0)
         r.position = 8'($urandom_range(0, node_count - 1));
      if (btin_pkg::func_type'(r.func) == btin_pkg::FUNC_REMOVE && node_count < 4 &&
          $urandom_range(0, 1))
         r.func = btin_pkg::FUNC_INSERT;
      return r;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [7:0] v);
      drain_results();
      req_valid <= 1'b0;
      psel      <= 1'b1;
      penable   <= 1'b0;
      pwrite    <= 1'b1;
      paddr     <= btin_pkg::REG_MAX_ENTRIES;
      pwdata    <= {24'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      fanout = int'(v);
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(btin_pkg::FUNC_LOOKUP, 32'd5, '0, '0, '0);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_REMOVE, '0, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_FIND, '0, '0, 31'd0, '0);
      send_op(btin_pkg::FUNC_INSERT, '1, '1, 31'd0, '0);
      send_op(btin_pkg::FUNC_NONE, '1, '1, '1, '1);
      send_op(btin_pkg::FUNC_NEW_ROOT, 32'h8000_0000, '1, 31'd0, '0);
      send_op(btin_pkg::FUNC_LOOKUP, 32'd0, '0, '0, '0);
      send_op(btin_pkg::FUNC_LOOKUP, 32'h8000_0000, '0, '0, '0);
      send_op(btin_pkg::FUNC_LOOKUP, '1, '0, '0, '0);
      send_op(btin_pkg::FUNC_INSERT, 32'd0, 31'h5555_5555, 31'd0, '0);
      send_op(btin_pkg::FUNC_INSERT, '1, 31'h2AAA_AAAA, '1, '0);
      send_op(btin_pkg::FUNC_INSERT, 32'd7, 31'd3, 31'd12345, '0);
      send_op(btin_pkg::FUNC_FIND, '0, '0, 31'h2AAA_AAAA, '0);
      send_op(btin_pkg::FUNC_FIND, '0, '0, 31'd999, '0);
      send_op(btin_pkg::FUNC_WRITE, 32'hDEAD_BEEF, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd3);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd4);
      send_op(btin_pkg::FUNC_LOOKUP, 32'd1, '0, '0, '0);
      send_op(btin_pkg::FUNC_REMOVE, '0, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_REMOVE, '0, '0, '0, 8'd255);
      send_op(btin_pkg::FUNC_WRITE, '1, '0, '0, 8'd255);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd0);
      send_op(btin_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, '0, '0, '0);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_item(random_item());
   endtask

   task automatic test_small_fanout();
      csr_write(8'd2);
      test_random(100);
      csr_write(8'd1);
      test_random(30);
      csr_write(8'd0);
      test_random(30);
   endtask

   // fill to the full 256 entries, then bump into the limit
   task automatic test_full_node();
      csr_write(8'd255);
      send_op(btin_pkg::FUNC_NEW_ROOT, 32'd10, 31'd1, 31'd0, '0);
      for (int i = 0; i < 256; i++)
         send_op(btin_pkg::FUNC_INSERT, $urandom, 31'($urandom),
                 node_kids[$urandom_range(0, node_count - 1)], '0);
      send_op(btin_pkg::FUNC_READ, '0, '0, '0, 8'd255);
      send_op(btin_pkg::FUNC_LOOKUP, $urandom, '0, '0, '0);
      send_op(btin_pkg::FUNC_REMOVE, '0, '0, '0, 8'd1);
      csr_write(8'd100);
      send_op(btin_pkg::FUNC_INSERT, '0, '0, node_kids[0], '0);
      send_op(btin_pkg::FUNC_FIND, '0, '0, node_kids[node_count - 1], '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      btin_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.child_out !== want.child_out || rsp_data.key_out !== want.key_out ||
                rsp_data.index_out !== want.index_out ||
                rsp_data.count_out !== want.count_out || rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_MAX) begin
         $display("FAIL btree_internal_node_engine");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      node_count = 0;
      fanout     = 255;
      key0_known = 1'b0;
      mismatches = 0;
      send_gaps  = 1'b1;
      stall_on   = 1'b1;
      for (int i = 0; i < CAP; i++) begin
         node_keys[i] = '0;
         node_kids[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_small_fanout();
      test_full_node();
      csr_write(8'd6);
      test_random(60);
      send_gaps = 1'b0;
      stall_on  = 1'b0;
      test_random(40);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("PASS btree_internal_node_engine");
      end else begin
         $display("FAIL btree_internal_node_engine");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/btin_pkg.sv
design/btin_store.sv
design/btree_internal_node_engine.sv
dv/tb_btree_internal_node_engine.sv
